// ----- design/uvc_descriptor_scanner_macros.svh -----
// assertion helpers for the descriptor scanner checks
`ifndef UVC_DESCRIPTOR_SCANNER_MACROS_SVH
`define UVC_DESCRIPTOR_SCANNER_MACROS_SVH

// clocked check, off while reset is held
`define UVCDS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("uvc_descriptor_scanner check failed");

// clocked check that also runs through reset
`define UVCDS_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("uvc_descriptor_scanner reset check failed");

`endif

// ----- design/uvcds_pkg.sv -----
package uvcds_pkg;

	localparam logic [7:0] T_CONFIG      = 8'h02;
	localparam logic [7:0] T_IFACE       = 8'h04;
	localparam logic [7:0] T_CS_IFACE    = 8'h24;
	localparam logic [7:0] CLASS_VIDEO   = 8'd14;
	localparam logic [7:0] SUB_VC        = 8'd1;
	localparam logic [7:0] ST_INPUT_TERM = 8'h02;
	localparam logic [7:0] ST_EXT_UNIT   = 8'h06;
	localparam logic [15:0] ITT_CAM      = 16'h0201;
	localparam logic [7:0] NONE_ID       = 8'hFF;
	localparam logic [7:0] XU_MIN_LEN    = 8'd24;
	localparam logic [7:0] IFACE_MIN_LEN = 8'd9;
	localparam logic [7:0] CS_MIN_LEN    = 8'd8;
	localparam logic [7:0] DESC_MIN_LEN  = 8'd2;

	localparam logic [7:0] CFG_XU_ID    = 8'd0;
	localparam logic [7:0] CFG_MODE_SEL = 8'd1;

	localparam logic [7:0] XU_ID_RST    = 8'd1;
	localparam logic [7:0] MODE_SEL_RST = 8'd1;

	typedef enum logic [3:0] {
		PH_SEEK = 4'b0001,
		PH_WALK = 4'b0010,
		PH_DONE = 4'b0100,
		PH_FAIL = 4'b1000
	} phase_t;

	typedef struct packed {
		logic [7:0] xu_id;
		logic [7:0] mode_sel;
	} cfg_t;

	typedef struct packed {
		logic       status;
		logic [7:0] vc_interface;
		logic [7:0] cam_terminal;
		logic [7:0] xu_unit;
		logic [7:0] xu_selector;
	} result_t;

endpackage

// ----- design/uvcds_walker.sv -----
module uvcds_walker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        data_byte,
	input  logic              last_byte,
	input  uvcds_pkg::cfg_t   cfg,
	output uvcds_pkg::result_t res
);
	import uvcds_pkg::*;

	phase_t      phase_q, phase_d;
	logic [7:0]  off_q, off_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  typ_q, typ_d;
	logic [15:0] rem_q, rem_d;
	logic [7:0]  tlow_q, tlow_d;
	logic [7:0]  cls_q, cls_d;
	logic [7:0]  sub_q, sub_d;
	logic [7:0]  vc_q, vc_d;
	logic [7:0]  cam_q, cam_d;
	logic [7:0]  xu_q, xu_d;
	logic [7:0]  sel_q, sel_d;

	logic [7:0]  cap_q [5];
	logic        cap_we;
	logic [2:0]  cap_idx;

	logic [15:0] t_w, t_m2, t_m3, t_m4;
	logic [15:0] b_w, tlow_w, len_w;
	logic        end_of_desc;
	logic        in_vc;

	assign b_w    = {8'd0, data_byte};
	assign tlow_w = {8'd0, tlow_q};
	assign len_w  = {8'd0, len_q};
	assign t_w    = {data_byte, tlow_q};
	assign t_m2   = t_w - 16'd2;
	assign t_m3   = t_w - 16'd3;
	assign t_m4   = t_w - 16'd4;

	assign end_of_desc = ({1'b0, off_q} + 9'd1) == {1'b0, len_q};
	assign in_vc       = (cls_q == CLASS_VIDEO) && (sub_q == SUB_VC);

	assign cap_we  = step && (phase_q == PH_WALK) && (off_q >= 8'd2) && (off_q <= 8'd6);
	assign cap_idx = 3'(off_q - 8'd2);

	always_comb begin
		phase_d = phase_q;
		off_d   = off_q;
		len_d   = len_q;
		typ_d   = typ_q;
		rem_d   = rem_q;
		tlow_d  = tlow_q;
		cls_d   = cls_q;
		sub_d   = sub_q;
		vc_d    = vc_q;
		cam_d   = cam_q;
		xu_d    = xu_q;
		sel_d   = sel_q;
		unique case (phase_q)
			PH_SEEK: begin
				if (off_q == 8'd0) begin
					len_d = data_byte;
					off_d = 8'd1;
				end else if (off_q == 8'd1) begin
					typ_d = data_byte;
					if (data_byte == T_CONFIG) begin
						off_d = 8'd2;
					end else if (len_q < DESC_MIN_LEN) begin
						phase_d = PH_FAIL;
					end else begin
						off_d = (len_q == DESC_MIN_LEN) ? 8'd0 : 8'd2;
					end
				end else if (typ_q != T_CONFIG) begin
					off_d = end_of_desc ? 8'd0 : off_q + 8'd1;
				end else if (off_q == 8'd2) begin
					tlow_d = data_byte;
					off_d  = 8'd3;
				end else begin
					// fourth config byte: replay the first four bytes through the walk at once
					phase_d = PH_WALK;
					off_d   = 8'd0;
					len_d   = 8'd0;
					typ_d   = 8'd0;
					rem_d   = t_w;
					if (t_w < 16'd2 || len_q < DESC_MIN_LEN || len_w > t_w) begin
						phase_d = PH_DONE;
					end else if (len_q == 8'd2) begin
						// next descriptor starts at the total-length low byte
						if (t_m2 < 16'd2 || tlow_q < DESC_MIN_LEN || tlow_w > t_m2) begin
							phase_d = PH_DONE;
							rem_d   = t_m2;
						end else begin
							len_d = tlow_q;
							typ_d = data_byte;
							if (tlow_q == 8'd2) begin
								rem_d = t_m4;
								off_d = 8'd0;
							end else begin
								rem_d = t_m2;
								off_d = 8'd2;
							end
						end
					end else if (len_q == 8'd3) begin
						// next descriptor starts at this byte
						rem_d = t_m3;
						typ_d = T_CONFIG;
						if (t_m3 < 16'd2 || data_byte < DESC_MIN_LEN || b_w > t_m3) begin
							phase_d = PH_DONE;
						end else begin
							len_d = data_byte;
							off_d = 8'd1;
						end
					end else begin
						len_d = len_q;
						typ_d = T_CONFIG;
						if (len_q == 8'd4) begin
							rem_d = t_m4;
							off_d = 8'd0;
						end else begin
							off_d = 8'd4;
						end
					end
				end
			end
			PH_WALK: begin
				if (off_q == 8'd0) begin
					if (rem_q < 16'd2 || data_byte < DESC_MIN_LEN || b_w > rem_q) begin
						phase_d = PH_DONE;
					end else begin
						len_d = data_byte;
						off_d = 8'd1;
					end
				end else begin
					if (off_q == 8'd1) begin
						typ_d = data_byte;
					end
					if (end_of_desc) begin
						// commit: any descriptor used here is at least 8 bytes, so type is settled
						if (typ_q == T_IFACE && len_q >= IFACE_MIN_LEN) begin
							cls_d = cap_q[3];
							sub_d = cap_q[4];
							if (cap_q[3] == CLASS_VIDEO && cap_q[4] == SUB_VC) begin
								vc_d = cap_q[0];
							end
						end
						if (typ_q == T_CS_IFACE && in_vc && len_q >= CS_MIN_LEN) begin
							if (cap_q[0] == ST_INPUT_TERM) begin
								if ({cap_q[3], cap_q[2]} == ITT_CAM) begin
									cam_d = cap_q[1];
								end
							end else if (cap_q[0] == ST_EXT_UNIT && len_q >= XU_MIN_LEN
									&& cap_q[1] == cfg.xu_id) begin
								xu_d  = cap_q[1];
								sel_d = cfg.mode_sel;
							end
						end
						rem_d = rem_q - len_w;
						off_d = 8'd0;
					end else begin
						off_d = off_q + 8'd1;
					end
				end
			end
			PH_DONE, PH_FAIL: begin
			end
			default: begin
				phase_d = PH_FAIL;
			end
		endcase
	end

	always_comb begin
		res.status       = (phase_d == PH_SEEK) || (phase_d == PH_FAIL)
				|| (vc_d == NONE_ID) || (cam_d == NONE_ID);
		res.vc_interface = vc_d;
		res.cam_terminal = cam_d;
		res.xu_unit      = xu_d;
		res.xu_selector  = sel_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEEK;
			off_q   <= 8'd0;
			len_q   <= 8'd0;
			typ_q   <= 8'd0;
			rem_q   <= 16'd0;
			tlow_q  <= 8'd0;
			cls_q   <= 8'd0;
			sub_q   <= 8'd0;
			vc_q    <= NONE_ID;
			cam_q   <= NONE_ID;
			xu_q    <= 8'd0;
			sel_q   <= 8'd0;
		end else if (step) begin
			if (last_byte) begin
				// blob done: back to the reset picture
				phase_q <= PH_SEEK;
				off_q   <= 8'd0;
				len_q   <= 8'd0;
				typ_q   <= 8'd0;
				rem_q   <= 16'd0;
				tlow_q  <= 8'd0;
				cls_q   <= 8'd0;
				sub_q   <= 8'd0;
				vc_q    <= NONE_ID;
				cam_q   <= NONE_ID;
				xu_q    <= 8'd0;
				sel_q   <= 8'd0;
			end else begin
				phase_q <= phase_d;
				off_q   <= off_d;
				len_q   <= len_d;
				typ_q   <= typ_d;
				rem_q   <= rem_d;
				tlow_q  <= tlow_d;
				cls_q   <= cls_d;
				sub_q   <= sub_d;
				vc_q    <= vc_d;
				cam_q   <= cam_d;
				xu_q    <= xu_d;
				sel_q   <= sel_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cap_we) begin
			cap_q[cap_idx] <= data_byte;
		end
	end

endmodule

// ----- design/uvc_descriptor_scanner.sv -----
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   data_byte, last_byte
// out       output     out_valid / out_ready status, vc_interface, cam_terminal, xu_unit,
//                                            xu_selector
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one byte per cycle sustained; a beat waits in the input register and the
// parse state updates as it leaves, a result is registered in the output register as
// its last byte leaves the input register. the input register stalls only when it
// holds a last byte while a result waits unaccepted in the output register.
// arst_n clears the parse state, both valids and the config registers to 1; cfg_ready is always high.
module uvc_descriptor_scanner (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic       status,
	output logic [7:0] vc_interface,
	output logic [7:0] cam_terminal,
	output logic [7:0] xu_unit,
	output logic [7:0] xu_selector,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data
);
	import uvcds_pkg::*;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       adv_s1;

	logic       out_valid_q;
	result_t    res_q;
	result_t    res;
	cfg_t       cfg_q;

	// a beat leaves the input register unless its result has nowhere to go
	assign adv_s1   = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
			last_s1 <= last_byte;
		end
	end

	uvcds_walker u_walker (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (adv_s1),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.cfg       (cfg_q),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (adv_s1 && last_s1) || (out_valid_q && !out_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && last_s1) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.xu_id    <= XU_ID_RST;
			cfg_q.mode_sel <= MODE_SEL_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_XU_ID:    cfg_q.xu_id    <= cfg_data;
				CFG_MODE_SEL: cfg_q.mode_sel <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = res_q.status;
	assign vc_interface = res_q.vc_interface;
	assign cam_terminal = res_q.cam_terminal;
	assign xu_unit      = res_q.xu_unit;
	assign xu_selector  = res_q.xu_selector;

endmodule

// ----- design/uvcds_checker.sv -----
`include "uvc_descriptor_scanner_macros.svh"

module uvcds_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       status,
	input logic [7:0] vc_interface,
	input logic [7:0] cam_terminal,
	input logic [7:0] xu_unit,
	input logic [7:0] xu_selector
);
	import uvcds_pkg::*;

	logic [32:0] out_beat;

	assign out_beat = {status, vc_interface, cam_terminal, xu_unit, xu_selector};

	// a stalled result beat holds
	`UVCDS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_beat))

	// success needs both the interface and the camera
	`UVCDS_ASSERT(a_ok_found, clk, arst_n, out_valid && !status |-> vc_interface != NONE_ID && cam_terminal != NONE_ID)

	// input only stalls behind a blocked result
	`UVCDS_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> out_valid && !out_ready)

	// no result can show up right out of reset
	`UVCDS_ASSERT_ALWAYS(a_reset_quiet, clk, !arst_n |=> !out_valid)

endmodule

bind uvc_descriptor_scanner uvcds_checker u_checker (.*);

// ----- dv/uvcds_findings_checker.sv -----
`timescale 1ns / 1ps

module uvcds_findings_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       status,
	input  logic [7:0] vc_interface,
	input  logic [7:0] cam_terminal,
	input  logic [7:0] xu_unit,
	input  logic [7:0] xu_selector,
	input  logic       cfg_valid,
	input  logic       cfg_ready,
	input  logic [7:0] cfg_index,
	input  logic [7:0] cfg_data,
	output int         mismatches,
	output int         pending
);
	import uvcds_pkg::*;

	// register copies
	logic [7:0] xu_want;
	logic [7:0] sel_cfg;

	// parse state of the scan in progress
	phase_t      ph;
	logic [7:0]  d_off;
	logic [7:0]  d_len;
	logic [7:0]  d_type;
	logic [15:0] cfg_left;
	logic [7:0]  tot_lo;
	logic [7:0]  cap [0:4];
	logic [7:0]  if_class;
	logic [7:0]  if_sub;
	logic [7:0]  vc_if;
	logic [7:0]  cam_id;
	logic [7:0]  xu_found;
	logic [7:0]  sel_found;
	logic        fail_flag;

	result_t findings_q [$];

	task automatic clear_scan();
		ph = PH_SEEK;
		d_off = 8'd0;
		d_len = 8'd0;
		d_type = 8'd0;
		cfg_left = 16'd0;
		tot_lo = 8'd0;
		for (int k = 0; k < 5; k++) cap[k] = 8'd0;
		if_class = 8'd0;
		if_sub = 8'd0;
		vc_if = NONE_ID;
		cam_id = NONE_ID;
		xu_found = 8'd0;
		sel_found = 8'd0;
		fail_flag = 1'b0;
	endtask

	task automatic apply_descriptor();
		if (d_type == T_IFACE && d_len >= IFACE_MIN_LEN) begin
			if_class = cap[3];
			if_sub = cap[4];
			if (if_class == CLASS_VIDEO && if_sub == SUB_VC)
				vc_if = cap[0];
		end
		if (d_type == T_CS_IFACE && if_class == CLASS_VIDEO && if_sub == SUB_VC &&
				d_len >= CS_MIN_LEN) begin
			if (cap[0] == ST_INPUT_TERM) begin
				if ({cap[3], cap[2]} == ITT_CAM)
					cam_id = cap[1];
			end else if (cap[0] == ST_EXT_UNIT && d_len >= XU_MIN_LEN && cap[1] == xu_want) begin
				xu_found = cap[1];
				sel_found = sel_cfg;
			end
		end
	endtask

	task automatic walk_window_byte(input logic [7:0] b);
		logic [7:0] off;
		bit stop;
		off = d_off;
		stop = 1'b0;
		if (ph != PH_WALK) begin
			stop = 1'b1;
		end else if (off == 8'd0) begin
			// short descriptor, overrun or exhausted window ends the walk
			if (cfg_left < 16'd2 || b < DESC_MIN_LEN || {8'd0, b} > cfg_left) begin
				ph = PH_DONE;
				stop = 1'b1;
			end else begin
				d_len = b;
			end
		end else if (off == 8'd1) begin
			d_type = b;
		end else if (off <= 8'd6) begin
			cap[3'(off - 8'd2)] = b;
		end
		if (!stop) begin
			if ({1'b0, off} + 9'd1 == {1'b0, d_len}) begin
				apply_descriptor();
				cfg_left = cfg_left - {8'd0, d_len};
				d_off = 8'd0;
			end else begin
				d_off = off + 8'd1;
			end
		end
	endtask

	task automatic seek_config_byte(input logic [7:0] b);
		logic [7:0] b0;
		logic [7:0] b1;
		logic [7:0] b2;
		if (d_off == 8'd0) begin
			d_len = b;
			d_off = 8'd1;
		end else if (d_off == 8'd1) begin
			d_type = b;
			if (b == T_CONFIG) begin
				d_off = 8'd2;
			end else if (d_len < DESC_MIN_LEN) begin
				ph = PH_FAIL;
				fail_flag = 1'b1;
			end else begin
				d_off = (d_len == DESC_MIN_LEN) ? 8'd0 : 8'd2;
			end
		end else if (d_type != T_CONFIG) begin
			d_off = ({1'b0, d_off} + 9'd1 == {1'b0, d_len}) ? 8'd0 : d_off + 8'd1;
		end else if (d_off == 8'd2) begin
			tot_lo = b;
			d_off = 8'd3;
		end else begin
			// the walk restarts over the first four bytes of the configuration
			b0 = d_len;
			b1 = d_type;
			b2 = tot_lo;
			ph = PH_WALK;
			cfg_left = {b, b2};
			d_off = 8'd0;
			d_len = 8'd0;
			d_type = 8'd0;
			walk_window_byte(b0);
			walk_window_byte(b1);
			walk_window_byte(b2);
			walk_window_byte(b);
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic last);
		result_t r;
		if (ph == PH_SEEK)
			seek_config_byte(b);
		else if (ph == PH_WALK)
			walk_window_byte(b);
		if (last) begin
			r.status = (ph == PH_SEEK || ph == PH_FAIL || fail_flag ||
				vc_if == NONE_ID || cam_id == NONE_ID);
			r.vc_interface = vc_if;
			r.cam_terminal = cam_id;
			r.xu_unit = xu_found;
			r.xu_selector = sel_found;
			findings_q.push_back(r);
			clear_scan();
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		$display("%0t: %s: got %0d, want %0d", $time, what, got, want);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t w;
		if (!arst_n) begin
			clear_scan();
			xu_want = XU_ID_RST;
			sel_cfg = MODE_SEL_RST;
			findings_q.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_XU_ID)
					xu_want = cfg_data;
				else if (cfg_index == CFG_MODE_SEL)
					sel_cfg = cfg_data;
			end
			// result beat first: it always belongs to an earlier byte
			if (out_valid && out_ready) begin
				if (findings_q.size() == 0) begin
					report_mismatch("result beat with none pending", vc_interface, 8'd0);
				end else begin
					w = findings_q.pop_front();
					if (status !== w.status)
						report_mismatch("status", {7'd0, status}, {7'd0, w.status});
					if (vc_interface !== w.vc_interface)
						report_mismatch("vc_interface", vc_interface, w.vc_interface);
					if (cam_terminal !== w.cam_terminal)
						report_mismatch("cam_terminal", cam_terminal, w.cam_terminal);
					if (xu_unit !== w.xu_unit)
						report_mismatch("xu_unit", xu_unit, w.xu_unit);
					if (xu_selector !== w.xu_selector)
						report_mismatch("xu_selector", xu_selector, w.xu_selector);
				end
			end
			if (in_valid && in_ready)
				scan_byte(data_byte, last_byte);
			pending = findings_q.size();
		end
	end

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
	import uvcds_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 360;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] data_byte = 8'd0;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic       status;
	logic [7:0] vc_interface;
	logic [7:0] cam_terminal;
	logic [7:0] xu_unit;
	logic [7:0] xu_selector;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [7:0] cfg_index = 8'd0;
	logic [7:0] cfg_data = 8'd0;

	int mismatches;
	int pending;

	int         cycles = 0;
	int         stall_left = 0;
	int         phase_bytes;
	bit         calm = 1'b0;
	logic [7:0] cur_xu = XU_ID_RST;
	logic [7:0] blob [$];

	uvc_descriptor_scanner uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .vc_interface(vc_interface), .cam_terminal(cam_terminal),
		.xu_unit(xu_unit), .xu_selector(xu_selector),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	uvcds_findings_checker u_findings (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.data_byte(data_byte), .last_byte(last_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.status(status), .vc_interface(vc_interface), .cam_terminal(cam_terminal),
		.xu_unit(xu_unit), .xu_selector(xu_selector),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("uvc_descriptor_scanner test failed");
			$finish;
		end
	end

	// result side back-pressure in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			out_ready <= 1'b0;
			stall_left <= $urandom_range(0, 18);
		end else begin
			out_ready <= 1'b1;
		end
	end

	function automatic logic [7:0] rb();
		return 8'($urandom);
	endfunction

	// length, type, bytes 2..6 as given, the rest random
	task automatic put_desc(input int len, input logic [7:0] typ, input logic [7:0] b2,
			input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
			input logic [7:0] b6);
		logic [7:0] f [0:4];
		f[0] = b2;
		f[1] = b3;
		f[2] = b4;
		f[3] = b5;
		f[4] = b6;
		blob.push_back(len[7:0]);
		blob.push_back(typ);
		for (int k = 2; k < len; k++)
			blob.push_back(k <= 6 ? f[k - 2] : rb());
	endtask

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		last_byte <= last;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	task automatic send_blob();
		for (int k = 0; k < blob.size(); k++)
			send_byte(blob[k], k == blob.size() - 1);
		phase_bytes += blob.size();
		blob.delete();
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		// the result register may still be settling
		repeat (4) @(posedge clk);
	endtask

	task automatic load_settings(input logic [7:0] xu_id, input logic [7:0] sel);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_XU_ID;
		cfg_data <= xu_id;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_index <= CFG_MODE_SEL;
		cfg_data <= sel;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_xu = xu_id;
	endtask

	task automatic build_random_blob();
		int lead;
		int parts;
		int cfg_at;
		int cfg_len;
		int body;
		int cut;
		logic [15:0] total;
		logic [7:0] tt_lo;
		logic [7:0] tt_hi;
		if ($urandom_range(0, 11) == 0) begin
			// pure noise
			repeat ($urandom_range(1, 40)) blob.push_back(rb());
		end else begin
			lead = $urandom_range(0, 2);
			repeat (lead) begin
				put_desc($urandom_range(0, 9) == 0 ? $urandom_range(0, 1) : $urandom_range(2, 12),
					$urandom_range(0, 1) ? 8'h01 : rb(), rb(), rb(), rb(), rb(), rb());
			end
			cfg_at = blob.size();
			cfg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8) : 9;
			put_desc(cfg_len, T_CONFIG, 8'd0, 8'd0, rb(), rb(), rb());
			parts = $urandom_range(1, 5);
			for (int k = 0; k < parts; k++) begin
				case ((k == 0 && $urandom_range(0, 3) != 0) ? 0 : $urandom_range(0, 5))
					0: put_desc(9, T_IFACE, rb(), rb(), rb(), CLASS_VIDEO, SUB_VC);
					1: put_desc($urandom_range(0, 4) == 0 ? $urandom_range(2, 8) : 9, T_IFACE,
						rb(), rb(), rb(), $urandom_range(0, 1) ? CLASS_VIDEO : rb(),
						8'($urandom_range(0, 3)));
					2, 3: begin
						tt_lo = ($urandom_range(0, 4) == 0) ? rb() : ITT_CAM[7:0];
						tt_hi = ($urandom_range(0, 4) == 0) ? rb() : ITT_CAM[15:8];
						put_desc($urandom_range(0, 5) == 0 ? $urandom_range(2, 7) :
							$urandom_range(8, 18), T_CS_IFACE, ST_INPUT_TERM, rb(), tt_lo, tt_hi, rb());
					end
					4: put_desc($urandom_range(0, 4) == 0 ? $urandom_range(8, 23) :
						$urandom_range(24, 30), T_CS_IFACE, ST_EXT_UNIT,
						$urandom_range(0, 3) == 0 ? rb() : cur_xu, rb(), rb(), rb());
					default: put_desc($urandom_range(0, 7) == 0 ? $urandom_range(0, 1) :
						$urandom_range(2, 10), rb(), rb(), rb(), rb(), rb(), rb());
				endcase
			end
			body = blob.size() - cfg_at;
			case ($urandom_range(0, 9))
				0: total = 16'($urandom_range(0, body));
				1: total = 16'(body + $urandom_range(1, 20));
				2: total = 16'($urandom);
				default: total = 16'(body);
			endcase
			if (cfg_len >= 4) begin
				blob[cfg_at + 2] = total[7:0];
				blob[cfg_at + 3] = total[15:8];
			end
			if ($urandom_range(0, 5) == 0)
				repeat ($urandom_range(1, 8)) blob.push_back(rb());
			// blob cut off somewhere
			if ($urandom_range(0, 9) == 0) begin
				cut = $urandom_range(1, blob.size());
				while (blob.size() > cut) void'(blob.pop_back());
			end
		end
	endtask

	initial begin
		logic [7:0] xu_id;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// blob ends while still seeking
		blob.push_back(8'hFF);
		send_blob();
		// short descriptor ahead of the configuration
		put_desc(1, 8'h05, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		blob.push_back(8'h00);
		send_blob();
		// configuration of length 2: the next descriptor starts in its total field
		put_desc(2, T_CONFIG, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
		blob.push_back(8'h02);
		blob.push_back(8'h00);
		send_blob();
		// minimal complete blob: interface 0, camera terminal 254
		put_desc(4, T_CONFIG, 8'd21, 8'd0, 8'd0, 8'd0, 8'd0);
		put_desc(9, T_IFACE, 8'd0, 8'd0, 8'd0, CLASS_VIDEO, SUB_VC);
		put_desc(8, T_CS_IFACE, ST_INPUT_TERM, 8'hFE, ITT_CAM[7:0], ITT_CAM[15:8], 8'd0);
		send_blob();

		for (int p = 1; p <= 5; p++) begin
			drain_results();
			case (p)
				1: load_settings(8'd255, 8'd0);
				2: load_settings(8'd1, 8'd255);
				default: begin
					xu_id = 8'($urandom_range(1, 255));
					load_settings(xu_id, rb());
				end
			endcase
			calm = (p == 5);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				build_random_blob();
				send_blob();
			end
		end

		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (10) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("uvc_descriptor_scanner test passed");
		else
			$display("uvc_descriptor_scanner test failed");
		$finish;
	end

endmodule
